// ----- src/memory_segment_map_unit_defines.svh -----
// Assertion macros for the segment map RTL.
`ifndef MEMORY_SEGMENT_MAP_UNIT_DEFINES_SVH
`define MEMORY_SEGMENT_MAP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSM_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSM_ASSERT(label, clk, rst_n, prop, msg)
`define MSM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- src/msm_pkg.sv -----
// Package with types, codes and constants of the segment map.
package msm_pkg;
	localparam int unsigned MaxSegmentsDefault = 64;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_FIND   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] start_addr;
		logic [63:0] end_addr;
		logic [7:0]  seg_type;
		logic [63:0] align;
		logic [63:0] need_bytes;
	} in_item_t;

	typedef struct packed {
		logic [63:0] found_addr;
		logic [1:0]  status;
		logic [6:0]  segment_count;
	} out_item_t;

	// Request to and reply from the remainder unit.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] remainder;
	} rem_rsp_t;
endpackage

// ----- src/msm_rem_unit.sv -----
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module msm_rem_unit
	import msm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], 1'b0};
			if (!trial[64]) begin
				rem_q <= trial[63:0];
			end else begin
				rem_q <= shifted[63:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;
endmodule

// ----- src/memory_segment_map_unit.sv -----
// Top level of the memory segment map: table storage, sequencer and handshakes.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+------------
//  in_item   | in        | in_valid/in_ready   | in_item_t
//  out_item  | out       | out_valid/out_ready | out_item_t
//
// Clear goes straight to the result; add and remove read and write table entries.
// Find visits the entries in order; each entry of the sought type is run through the
// bit-serial remainder unit, and any other entry is skipped after its type check. Reset
// empties the table at once (the count is zeroed); entry contents stay undefined until
// written. in_ready is low from acceptance until the result item has been taken, so a
// stalled output holds the block.
`include "memory_segment_map_unit_defines.svh"
module memory_segment_map_unit
	import msm_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);
	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD_LAST, S_RD_PREV, S_DECIDE, S_WR2, S_WR3,
		S_F_RD, S_F_WAIT, S_F_TYPE, S_F_DIV, S_F_CHK, S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] s;
		logic [63:0] e;
		logic [7:0]  t;
	} entry_t;

	entry_t mem [MAX_SEGMENTS];
	entry_t rd_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	state_t    state_q;
	in_item_t  req_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	entry_t    last_q;
	entry_t    prev_q;
	logic      prev_ok_q;
	logic [63:0] align_q;
	out_item_t res_q;
	logic      rem_start_q;
	logic [63:0] rem_dvd_q;
	logic [63:0] rem_dvs_q;
	rem_req_t  rreq;
	rem_rsp_t  rrsp;

	logic [CW:0] cnt_ext;
	assign cnt_ext = {1'b0, cnt_q};

	assign rreq = '{rem_start_q, rem_dvd_q, rem_dvs_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	msm_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rreq),
		.rsp    (rrsp)
	);

	// Find arithmetic on the current entry.
	logic [63:0] up;
	logic [64:0] cand;
	logic [63:0] aligned;
	logic        fits;
	assign up      = align_q - rrsp.remainder;
	assign cand    = (rrsp.remainder == 64'd0) ? {1'b0, rd_q.s} : {1'b0, rd_q.s} + {1'b0, up};
	assign aligned = cand[63:0];
	assign fits    = !cand[64] && (aligned < rd_q.e) &&
		((req_q.need_bytes == 64'd0) || (rd_q.e - aligned >= req_q.need_bytes - 64'd1));

	logic [IW-1:0] last_idx;
	logic [IW-1:0] prev_idx;
	assign last_idx = IW'(cnt_q - CW'(1));
	assign prev_idx = IW'(cnt_q - CW'(2));

	always_comb begin
		rd_addr = idx_q[IW-1:0];
		case (state_q)
			S_RD_LAST: rd_addr = last_idx;
			S_RD_PREV: rd_addr = prev_idx;
			default:   rd_addr = idx_q[IW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			wr_en       <= 1'b0;
			rem_start_q <= 1'b0;
		end else begin
			wr_en       <= 1'b0;
			rem_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_item;
						res_q.found_addr <= '0;
						res_q.status <= ST_DONE;
						idx_q <= '0;
						align_q <= (in_item.align == 64'd0) ? 64'd1 : in_item.align;
						case (kind_t'(in_item.kind))
							KIND_CLEAR: begin
								cnt_q <= '0;
								res_q.segment_count <= '0;
								state_q <= S_OUT;
							end
							KIND_FIND: state_q <= S_F_RD;
							default: begin
								if (cnt_q == '0) begin
									if (in_item.kind == KIND_REMOVE) begin
										res_q.status <= ST_EMPTY;
										res_q.segment_count <= 7'(cnt_q);
										state_q <= S_OUT;
									end else begin
										wr_en <= 1'b1;
										wr_addr <= '0;
										wr_data <= '{in_item.start_addr, in_item.end_addr,
											in_item.seg_type};
										cnt_q <= CW'(1);
										res_q.segment_count <= 7'd1;
										state_q <= S_OUT;
									end
								end else begin
									state_q <= S_RD_LAST;
								end
							end
						endcase
					end
				end
				S_RD_LAST: state_q <= (cnt_q >= CW'(2)) ? S_RD_PREV : S_DECIDE;
				S_RD_PREV: begin
					last_q <= rd_q;
					prev_ok_q <= 1'b0;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					entry_t le;
					logic [CW:0] nc;
					le = (cnt_q >= CW'(2)) ? last_q : rd_q;
					nc = cnt_ext;
					state_q <= S_OUT;
					if (req_q.kind == KIND_ADD) begin
						if (le.e + 64'd1 == req_q.start_addr && le.t == req_q.seg_type) begin
							wr_en <= 1'b1;
							wr_addr <= last_idx;
							wr_data <= '{le.s, req_q.end_addr, le.t};
						end else if (cnt_ext >= (CW+1)'(MAX_SEGMENTS)) begin
							res_q.status <= ST_FULL;
						end else begin
							wr_en <= 1'b1;
							wr_addr <= IW'(cnt_q);
							wr_data <= '{req_q.start_addr, req_q.end_addr, req_q.seg_type};
							nc = cnt_ext + (CW+1)'(1);
						end
					end else if (cnt_q >= CW'(2) && rd_q.e + 64'd1 == req_q.start_addr &&
						rd_q.t == req_q.seg_type) begin
						wr_en <= 1'b1;
						wr_addr <= prev_idx;
						wr_data <= '{rd_q.s, req_q.end_addr, rd_q.t};
						if (le.e == req_q.end_addr) begin
							nc = cnt_ext - (CW+1)'(1);
						end else begin
							last_q <= '{req_q.end_addr + 64'd1, le.e, le.t};
							prev_ok_q <= 1'b1;
							state_q <= S_WR3;
						end
					end else if (le.s == req_q.start_addr && le.e == req_q.end_addr) begin
						wr_en <= 1'b1;
						wr_addr <= last_idx;
						wr_data <= '{le.s, le.e, req_q.seg_type};
					end else if (le.s == req_q.start_addr || le.e == req_q.end_addr) begin
						if (cnt_ext + (CW+1)'(1) > (CW+1)'(MAX_SEGMENTS)) begin
							res_q.status <= ST_FULL;
						end else begin
							wr_en <= 1'b1;
							wr_addr <= last_idx;
							if (le.s == req_q.start_addr) begin
								wr_data <= '{le.s, req_q.end_addr, req_q.seg_type};
								prev_q <= '{req_q.end_addr + 64'd1, le.e, le.t};
							end else begin
								wr_data <= '{le.s, req_q.start_addr - 64'd1, le.t};
								prev_q <= '{req_q.start_addr, le.e, req_q.seg_type};
							end
							idx_q <= cnt_q;
							nc = cnt_ext + (CW+1)'(1);
							state_q <= S_WR2;
						end
					end else begin
						if (cnt_ext + (CW+1)'(2) > (CW+1)'(MAX_SEGMENTS)) begin
							res_q.status <= ST_FULL;
						end else begin
							wr_en <= 1'b1;
							wr_addr <= last_idx;
							wr_data <= '{le.s, req_q.start_addr - 64'd1, le.t};
							prev_q <= '{req_q.start_addr, req_q.end_addr, req_q.seg_type};
							last_q <= '{req_q.end_addr + 64'd1, le.e, le.t};
							prev_ok_q <= 1'b0;
							idx_q <= cnt_q;
							nc = cnt_ext + (CW+1)'(2);
							state_q <= S_WR2;
						end
					end
					cnt_q <= CW'(nc);
					res_q.segment_count <= 7'(nc);
				end
				S_WR2: begin
					wr_en <= 1'b1;
					wr_addr <= idx_q[IW-1:0];
					wr_data <= prev_q;
					idx_q <= idx_q + CW'(1);
					state_q <= (cnt_q == idx_q + CW'(1)) ? S_OUT : S_WR3;
				end
				S_WR3: begin
					wr_en <= 1'b1;
					wr_addr <= prev_ok_q ? last_idx : idx_q[IW-1:0];
					wr_data <= last_q;
					state_q <= S_OUT;
				end
				S_F_RD: begin
					res_q.segment_count <= 7'(cnt_q);
					if (idx_q >= cnt_q) begin
						res_q.status <= ST_NOFIT;
						state_q <= S_OUT;
					end else begin
						state_q <= S_F_WAIT;
					end
				end
				S_F_WAIT: state_q <= S_F_TYPE;
				S_F_TYPE: begin
					if (rd_q.t != req_q.seg_type) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_F_RD;
					end else begin
						rem_start_q <= 1'b1;
						state_q <= S_F_DIV;
					end
				end
				S_F_DIV: begin
					if (rrsp.done) begin
						state_q <= S_F_CHK;
					end
				end
				S_F_CHK: begin
					if (fits) begin
						res_q.found_addr <= aligned;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_F_RD;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_F_TYPE) begin
			rem_dvd_q <= rd_q.s;
			rem_dvs_q <= align_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_item  = res_q;

	logic in_acc;
	logic clear_acc;
	logic out_stall;
	assign in_acc    = in_valid && in_ready;
	assign clear_acc = in_acc && (in_item.kind == KIND_CLEAR);
	assign out_stall = out_valid && !out_ready;

	`MSM_ASSERT(a_cnt_range, clk, arst_n, cnt_ext <= (CW+1)'(MAX_SEGMENTS), "count too high")
	`MSM_ASSERT(a_no_overlap, clk, arst_n, !(in_ready && out_valid), "ready while result pending")
	`MSM_ASSERT(a_cnt_hold, clk, arst_n, out_stall |=> $stable(cnt_q), "count moved in stall")
	`MSM_ASSERT(a_clear_zero, clk, arst_n, clear_acc |=> (cnt_q == '0), "clear left entries")
endmodule

// ----- dv/msm_checker.sv -----
// Checker that predicts segment map results and compares them with the block's output.
module msm_checker
	import msm_pkg::*;
#(
	parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	output int        errors,
	output int        pending,
	output int        found_hits,
	output int        full_drops
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] tbl_start [MAX_SEGMENTS];
	logic [63:0] tbl_end [MAX_SEGMENTS];
	logic [7:0]  tbl_type [MAX_SEGMENTS];
	int unsigned tbl_count;
	out_item_t   expected_q[$];
	int          result_num;

	initial begin
		errors = 0;
		pending = 0;
		found_hits = 0;
		full_drops = 0;
		tbl_count = 0;
		result_num = 0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH result %0d %s: got %0h expected %0h", result_num, what, got, want);
		errors++;
	endtask

	function automatic void put_seg(int unsigned i, logic [63:0] s, logic [63:0] e,
			logic [7:0] t);
		tbl_start[i] = s;
		tbl_end[i] = e;
		tbl_type[i] = t;
	endfunction

	function automatic status_t add_range(logic [63:0] s, logic [63:0] e, logic [7:0] t);
		int unsigned n;
		n = tbl_count;
		if (n >= 1 && tbl_end[n-1] + 64'd1 == s && tbl_type[n-1] == t) begin
			tbl_end[n-1] = e;
			return ST_DONE;
		end
		if (n >= MAX_SEGMENTS) return ST_FULL;
		put_seg(n, s, e, t);
		tbl_count = n + 1;
		return ST_DONE;
	endfunction

	function automatic status_t carve_range(logic [63:0] s, logic [63:0] e, logic [7:0] t);
		int unsigned n, last;
		logic [63:0] ls, le;
		logic [7:0]  lt;
		n = tbl_count;
		if (n == 0) return ST_EMPTY;
		last = n - 1;
		// The carved range may simply grow the entry before the last one.
		if (n >= 2 && tbl_end[n-2] + 64'd1 == s && tbl_type[n-2] == t) begin
			tbl_end[n-2] = e;
			if (tbl_end[last] == e) tbl_count = last;
			else tbl_start[last] = e + 64'd1;
			return ST_DONE;
		end
		ls = tbl_start[last];
		le = tbl_end[last];
		lt = tbl_type[last];
		if (ls == s) begin
			if (le == e) begin
				tbl_type[last] = t;
				return ST_DONE;
			end
			if (n + 1 > MAX_SEGMENTS) return ST_FULL;
			put_seg(last, s, e, t);
			put_seg(n, e + 64'd1, le, lt);
			tbl_count = n + 1;
			return ST_DONE;
		end
		if (le == e) begin
			if (n + 1 > MAX_SEGMENTS) return ST_FULL;
			put_seg(last, ls, s - 64'd1, lt);
			put_seg(n, s, le, t);
			tbl_count = n + 1;
			return ST_DONE;
		end
		if (n + 2 > MAX_SEGMENTS) return ST_FULL;
		put_seg(last, ls, s - 64'd1, lt);
		put_seg(n, s, e, t);
		put_seg(n + 1, e + 64'd1, le, lt);
		tbl_count = n + 2;
		return ST_DONE;
	endfunction

	function automatic logic find_fit(logic [63:0] align, logic [63:0] need, logic [7:0] t,
			output logic [63:0] addr);
		logic [63:0] a, rem, up, s;
		a = (align == 0) ? 64'd1 : align;
		addr = '0;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_type[i] != t) continue;
			rem = tbl_start[i] % a;
			if (rem == 0) s = tbl_start[i];
			else begin
				up = a - rem;
				if (tbl_start[i] > ~up) continue;
				s = tbl_start[i] + up;
			end
			if (s >= tbl_end[i]) continue;
			if (need == 0 || tbl_end[i] - s >= need - 64'd1) begin
				addr = s;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		out_item_t   want;
		logic [63:0] addr;
		if (arst_n && in_valid && in_ready) begin
			want = '0;
			want.status = ST_DONE;
			case (kind_t'(in_item.kind))
				KIND_CLEAR:  tbl_count = 0;
				KIND_ADD:    want.status = add_range(in_item.start_addr, in_item.end_addr,
						in_item.seg_type);
				KIND_REMOVE: want.status = carve_range(in_item.start_addr, in_item.end_addr,
						in_item.seg_type);
				default: begin
					if (find_fit(in_item.align, in_item.need_bytes, in_item.seg_type,
							addr)) begin
						want.found_addr = addr;
						found_hits++;
					end else
						want.status = ST_NOFIT;
				end
			endcase
			if (want.status == ST_FULL) full_drops++;
			want.segment_count = tbl_count[6:0];
			expected_q.push_back(want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("item with nothing expected", out_item.found_addr, 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (out_item.found_addr !== want.found_addr)
					report_mismatch("found_addr", out_item.found_addr, want.found_addr);
				if (out_item.status !== want.status)
					report_mismatch("status", 64'(out_item.status), 64'(want.status));
				if (out_item.segment_count !== want.segment_count)
					report_mismatch("segment_count", 64'(out_item.segment_count),
							64'(want.segment_count));
			end
			result_num++;
		end
		pending = expected_q.size();
	end
endmodule

// ----- dv/tb.sv -----
// Testbench top: drives segment map items, stalls the output, and gives the verdict.
module tb;
	import msm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MaxSeg = MaxSegmentsDefault;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	int        errors, pending, found_hits, full_drops;

	// Idling controls for the sender and the receiver.
	logic quiet = 1'b0;
	logic hold_off = 1'b0;
	int   sent = 0;

	// Model of the table tail, kept so that well-formed removes can be aimed at it.
	logic [63:0] tail_start, tail_end, next_free;
	logic [7:0]  tail_type;
	int          tail_valid = 0;

	always #5 clk = ~clk;

	memory_segment_map_unit #(.MAX_SEGMENTS(MaxSeg)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	msm_checker #(.MAX_SEGMENTS(MaxSeg)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.errors(errors), .pending(pending), .found_hits(found_hits), .full_drops(full_drops)
	);

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Addresses that hit extremes, small values, or anything at all.
	function automatic logic [63:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1;
			2: return 64'($urandom_range(0, 4096));
			3: return '1 - 64'($urandom_range(0, 4096));
			default: return rand64();
		endcase
	endfunction

	function automatic in_item_t make_item(kind_t k, logic [63:0] s, logic [63:0] e,
			logic [7:0] t, logic [63:0] al, logic [63:0] sz);
		in_item_t it;
		it.kind = k;
		it.start_addr = s;
		it.end_addr = e;
		it.seg_type = t;
		it.align = al;
		it.need_bytes = sz;
		return it;
	endfunction

	// Offers one item, idling first at random, and waits for it to be taken.
	// Valid stays high after the item is taken so that the next item can follow at once.
	task automatic send_item(input in_item_t it);
		if (!quiet && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (!quiet && $urandom_range(0, 99) < 17) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Builds one item; mostly a well-formed table building step, sometimes noise.
	function automatic in_item_t next_random_item();
		logic [63:0] s, e, len;
		logic [7:0]  t;
		int          pick;
		pick = $urandom_range(0, 99);
		t = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 19) == 0) t = 8'($urandom());
		if (pick < 3) return make_item(KIND_CLEAR, rand64(), rand64(), 8'($urandom()),
				rand64(), rand64());
		if (pick < 40) begin
			len = 64'($urandom_range(0, 5000));
			if ($urandom_range(0, 9) == 0) s = pick_addr();
			else s = next_free;
			return make_item(KIND_ADD, s, s + len, t, rand64(), rand64());
		end
		if (pick < 65 && tail_valid != 0) begin
			// Carve inside the tail, at its head, its end, or the whole of it.
			s = tail_start + 64'($urandom_range(0, 3));
			e = tail_end - 64'($urandom_range(0, 3));
			case ($urandom_range(0, 4))
				0: s = tail_start;
				1: e = tail_end;
				2: begin s = tail_start; e = tail_end; end
				default: ;
			endcase
			return make_item(KIND_REMOVE, s, e, t, rand64(), rand64());
		end
		if (pick < 70) return make_item(KIND_REMOVE, pick_addr(), pick_addr(), t,
				rand64(), rand64());
		case ($urandom_range(0, 3))
			0: return make_item(KIND_FIND, rand64(), rand64(), t, pick_addr(), pick_addr());
			default: return make_item(KIND_FIND, rand64(), rand64(), t,
					64'(1) << $urandom_range(0, 12), 64'($urandom_range(0, 6000)));
		endcase
	endfunction

	// Keeps the rough view of the table tail up to date after an item is taken.
	function automatic void track_tail(in_item_t it);
		case (kind_t'(it.kind))
			KIND_CLEAR: tail_valid = 0;
			KIND_ADD: begin
				tail_start = it.start_addr;
				tail_end = it.end_addr;
				tail_type = it.seg_type;
				tail_valid = 1;
				next_free = it.end_addr + 64'd1;
			end
			KIND_REMOVE: if (tail_valid != 0 && it.end_addr != tail_end &&
					it.end_addr >= it.start_addr) tail_start = it.end_addr + 64'd1;
			default: ;
		endcase
	endfunction

	// Receiver: random stalls, plus a long hold-off when asked.
	initial begin
		forever begin
			@(posedge clk);
			out_ready <= !hold_off && (quiet || $urandom_range(0, 99) >= 17);
		end
	end

	initial begin
		#300ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		in_item_t it;
		int       hold;
		next_free = 64'h1000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table cases, extremes, merges and every kind of carve.
		send_item(make_item(KIND_REMOVE, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_FIND, 0, 0, 0, 0, 0));
		send_item(make_item(KIND_ADD, 0, '1, 8'hFF, 0, 0));
		send_item(make_item(KIND_FIND, 0, 0, 8'hFF, 0, '1));
		send_item(make_item(KIND_FIND, 0, 0, 8'hFF, '1, 0));
		send_item(make_item(KIND_FIND, 0, 0, 8'hFF, 64'd16, 0));
		send_item(make_item(KIND_CLEAR, '1, '1, 8'hFF, '1, '1));
		send_item(make_item(KIND_ADD, 64'h100, 64'h1FF, 8'd1, 0, 0));
		send_item(make_item(KIND_ADD, 64'h200, 64'h2FF, 8'd1, 0, 0));
		send_item(make_item(KIND_ADD, 64'h300, 64'h3FF, 8'd2, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h300, 64'h33F, 8'd1, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h340, 64'h3FF, 8'd1, 0, 0));
		send_item(make_item(KIND_ADD, 64'h500, 64'h5FF, 8'd3, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h500, 64'h5FF, 8'd4, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h500, 64'h51F, 8'd5, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h540, 64'h5FF, 8'd6, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h550, 64'h55F, 8'd7, 0, 0));
		send_item(make_item(KIND_ADD, '1 - 64'd2, '1, 8'd9, 0, 0));
		send_item(make_item(KIND_FIND, 0, 0, 8'd9, 64'd8, 0));
		send_item(make_item(KIND_FIND, 0, 0, 8'd9, 64'd2, 64'd2));
		send_item(make_item(KIND_FIND, 0, 0, 8'd7, 0, 64'd16));
		send_item(make_item(KIND_ADD, 64'h10, 64'h8, 8'd7, 0, 0));
		send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0));
		// Fill the table to capacity, then try an add and a split that must be dropped.
		for (int i = 0; i < MaxSeg; i++)
			send_item(make_item(KIND_ADD, 64'(i) * 64'h100, 64'(i) * 64'h100 + 64'h7F,
					8'(i % 4), 0, 0));
		send_item(make_item(KIND_ADD, 64'h9000, 64'h90FF, 8'd1, 0, 0));
		send_item(make_item(KIND_REMOVE, 64'h3F10, 64'h3F1F, 8'd9, 0, 0));
		send_item(make_item(KIND_FIND, 0, 0, 8'd3, 64'h40, 64'h40));
		send_item(make_item(KIND_CLEAR, 0, 0, 0, 0, 0));
		tail_valid = 0;

		// Random part, with a quiet stretch and one long output hold-off.
		for (int n = 0; n < 650; n++) begin
			quiet <= (n >= 200 && n < 300);
			if (n == 400) begin
				hold_off <= 1'b1;
				fork
					begin
						hold = 0;
						while (hold < 300) begin
							@(posedge clk);
							hold++;
						end
						hold_off <= 1'b0;
					end
				join_none
			end
			it = next_random_item();
			send_item(it);
			track_tail(it);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d items: %0d finds that fit, %0d items dropped on a full table.",
				sent, found_hits, full_drops);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ----- memory_segment_map_unit.f -----
+incdir+src
src/msm_pkg.sv
src/msm_rem_unit.sv
src/memory_segment_map_unit.sv
dv/msm_checker.sv
dv/tb.sv
